FILE: rtl/core/gdfs_pkg.sv
// ----------------------------------------------------------------------------
// gdfs_pkg
// Shared types and constants of the grid maze depth-first solver.
// ----------------------------------------------------------------------------
package gdfs_pkg;

  localparam int ROW_W  = 6;
  localparam int COL_W  = 6;
  localparam int LEN_W  = 13;
  localparam int IDX_W  = 12;
  localparam int DIM_W  = 7;

  localparam logic [DIM_W-1:0] DIM_MIN = 7'd3;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_SOLVE = 2'd1,
    CMD_READ  = 2'd2
  } cmd_code_t;

  localparam logic [1:0] DIR_DOWN  = 2'd0;
  localparam logic [1:0] DIR_RIGHT = 2'd1;
  localparam logic [1:0] DIR_UP    = 2'd2;
  localparam logic [1:0] DIR_LEFT  = 2'd3;

  localparam logic [1:0] REG_GRID_ROWS = 2'd0;
  localparam logic [1:0] REG_GRID_COLS = 2'd1;
  localparam logic [1:0] REG_EXIT_ROW  = 2'd2;
  localparam logic [1:0] REG_EXIT_COL  = 2'd3;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [ROW_W-1:0] cell_row;
    logic [COL_W-1:0] cell_col;
    logic             cell_blocked;
    logic [IDX_W-1:0] path_index;
  } req_t;

  typedef struct packed {
    logic             found;
    logic [LEN_W-1:0] path_length;
    logic [ROW_W-1:0] step_row;
    logic [COL_W-1:0] step_col;
    logic [1:0]       step_dir;
    logic             index_valid;
  } res_t;

  // controller -> datapath
  typedef struct packed {
    logic active;
    logic init;
    logic clr_we;
    logic visit;
    logic next_dir;
    logic push;
    logic set_found;
    logic pop_rd;
    logic pop_load;
    logic finish;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_last;
    logic nb_ok;
    logic nb_free;
    logic at_exit;
    logic dir_last;
    logic depth_zero;
  } ctrl_sts_t;

endpackage

FILE: rtl/core/gdfs_ram.sv
// ----------------------------------------------------------------------------
// gdfs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gdfs_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/gdfs_ctrl.sv
// ----------------------------------------------------------------------------
// gdfs_ctrl
// Sequencer of the depth-first walk: clear, visit, probe, push and pop.
// ----------------------------------------------------------------------------
module gdfs_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 solve_go,
  input  gdfs_pkg::ctrl_sts_t  sts,
  output gdfs_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_VISIT,
    S_PROBE,
    S_CHECK,
    S_STUCK,
    S_POP
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.active = (state != S_IDLE);
    case (state)
      S_IDLE: begin
        if (solve_go) begin
          cmd.init   = 1'b1;
          state_next = S_CLEAR;
        end
      end
      S_CLEAR: begin
        cmd.clr_we = 1'b1;
        if (sts.clr_last) begin
          state_next = S_VISIT;
        end
      end
      S_VISIT: begin
        cmd.visit  = 1'b1;
        state_next = S_PROBE;
      end
      S_PROBE: begin
        // map read of the neighbor is in flight when nb_ok
        if (sts.nb_ok) begin
          state_next = S_CHECK;
        end else if (sts.dir_last) begin
          state_next = S_STUCK;
        end else begin
          cmd.next_dir = 1'b1;
        end
      end
      S_CHECK: begin
        if (sts.nb_free) begin
          cmd.push = 1'b1;
          if (sts.at_exit) begin
            cmd.set_found = 1'b1;
            cmd.finish    = 1'b1;
            state_next    = S_IDLE;
          end else begin
            state_next = S_VISIT;
          end
        end else if (sts.dir_last) begin
          state_next = S_STUCK;
        end else begin
          cmd.next_dir = 1'b1;
          state_next   = S_PROBE;
        end
      end
      S_STUCK: begin
        if (sts.depth_zero) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.pop_rd = 1'b1;
          state_next = S_POP;
        end
      end
      S_POP: begin
        cmd.pop_load = 1'b1;
        state_next   = S_VISIT;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/core/gdfs_dp.sv
// ----------------------------------------------------------------------------
// gdfs_dp
// Walk datapath: position, direction, path stack, wall and visited maps,
// and the result register.
// ----------------------------------------------------------------------------
module gdfs_dp #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             accept,
  input  gdfs_pkg::req_t                   req,
  input  logic [gdfs_pkg::DIM_W-1:0]       grid_rows,
  input  logic [gdfs_pkg::DIM_W-1:0]       grid_cols,
  input  logic [gdfs_pkg::ROW_W-1:0]       exit_row,
  input  logic [gdfs_pkg::COL_W-1:0]       exit_col,
  input  gdfs_pkg::ctrl_cmd_t              cmd,
  output gdfs_pkg::ctrl_sts_t              sts,
  output logic                             done,
  output gdfs_pkg::res_t                   res
);

  localparam int RW        = $clog2(MAX_ROWS);
  localparam int CW        = $clog2(MAX_COLS);
  localparam int MW        = RW + CW;
  localparam int MAP_DEPTH = 1 << MW;
  localparam int CELLS     = MAX_ROWS * MAX_COLS;
  localparam int SAW       = $clog2(CELLS);
  localparam int DW        = $clog2(CELLS + 1);
  localparam int EW        = RW + CW + 2;
  localparam int CMPW0     = (RW > CW) ? RW : CW;
  localparam int CMPW      = ((CMPW0 > gdfs_pkg::DIM_W) ? CMPW0 : gdfs_pkg::DIM_W) + 1;
  localparam int IDXW      = (DW > gdfs_pkg::IDX_W) ? DW : gdfs_pkg::IDX_W;
  localparam int LW        = (DW > gdfs_pkg::LEN_W) ? DW : gdfs_pkg::LEN_W;
  localparam int ORW       = (RW > gdfs_pkg::ROW_W) ? RW : gdfs_pkg::ROW_W;
  localparam int OCW       = (CW > gdfs_pkg::COL_W) ? CW : gdfs_pkg::COL_W;

  logic [RW-1:0] cur_row;
  logic [CW-1:0] cur_col;
  logic [1:0]    dir;
  logic [DW-1:0] depth;
  logic          found;
  logic [MW-1:0] clr_cnt;
  logic          rd_valid;

  logic [RW-1:0]   nb_row;
  logic [CW-1:0]   nb_col;
  logic            in_bounds;
  logic [CMPW-1:0] cur_row_x;
  logic [CMPW-1:0] cur_col_x;
  logic [CMPW-1:0] rows_x;
  logic [CMPW-1:0] cols_x;
  logic [CMPW-1:0] start_row_x;
  logic [CMPW-1:0] start_col_x;
  logic [CMPW-1:0] wr_row_x;
  logic [CMPW-1:0] wr_col_x;
  logic            wr_in_range;

  logic          wall_q;
  logic          vis_q;
  logic [EW-1:0] stk_q;
  logic [DW-1:0] depth_m1;
  logic [IDXW-1:0] idx_x;
  logic            idx_hit;
  logic [LW-1:0]   len_x;
  logic [ORW-1:0]  step_row_x;
  logic [OCW-1:0]  step_col_x;

  assign cur_row_x   = CMPW'(cur_row);
  assign cur_col_x   = CMPW'(cur_col);
  assign rows_x      = CMPW'(grid_rows);
  assign cols_x      = CMPW'(grid_cols);
  assign start_row_x = rows_x >> 1;
  assign start_col_x = cols_x >> 1;
  assign wr_row_x    = CMPW'(req.cell_row);
  assign wr_col_x    = CMPW'(req.cell_col);
  assign wr_in_range = (wr_row_x < CMPW'(MAX_ROWS)) && (wr_col_x < CMPW'(MAX_COLS));

  // neighbor in the current direction; cells off the grid read as walls
  always_comb begin
    nb_row    = cur_row;
    nb_col    = cur_col;
    in_bounds = 1'b0;
    case (dir)
      gdfs_pkg::DIR_DOWN: begin
        nb_row    = cur_row + RW'(1);
        in_bounds = (cur_row_x + CMPW'(1)) < rows_x;
      end
      gdfs_pkg::DIR_RIGHT: begin
        nb_col    = cur_col + CW'(1);
        in_bounds = (cur_col_x + CMPW'(1)) < cols_x;
      end
      gdfs_pkg::DIR_UP: begin
        nb_row    = cur_row - RW'(1);
        in_bounds = (cur_row != '0);
      end
      gdfs_pkg::DIR_LEFT: begin
        nb_col    = cur_col - CW'(1);
        in_bounds = (cur_col != '0);
      end
      default: begin
        in_bounds = 1'b0;
      end
    endcase
  end

  assign sts.clr_last   = &clr_cnt;
  assign sts.nb_ok      = in_bounds && (depth < DW'(CELLS));
  assign sts.nb_free    = !wall_q && !vis_q;
  assign sts.at_exit    = (CMPW'(nb_row) == CMPW'(exit_row)) &&
                          (CMPW'(nb_col) == CMPW'(exit_col));
  assign sts.dir_last   = (dir == gdfs_pkg::DIR_LEFT);
  assign sts.depth_zero = (depth == '0);

  assign depth_m1 = depth - DW'(1);
  assign idx_x    = IDXW'(req.path_index);
  assign idx_hit  = idx_x < IDXW'(depth);

  gdfs_ram #(.WIDTH(1), .DEPTH(MAP_DEPTH)) u_wall (
    .clk   (clk),
    .we    (accept && (req.cmd == gdfs_pkg::CMD_WRITE) && wr_in_range),
    .waddr ({wr_row_x[RW-1:0], wr_col_x[CW-1:0]}),
    .wdata (req.cell_blocked),
    .raddr ({nb_row, nb_col}),
    .rdata (wall_q)
  );

  gdfs_ram #(.WIDTH(1), .DEPTH(MAP_DEPTH)) u_visited (
    .clk   (clk),
    .we    (cmd.clr_we || cmd.visit),
    .waddr (cmd.clr_we ? clr_cnt : {cur_row, cur_col}),
    .wdata (cmd.visit),
    .raddr ({nb_row, nb_col}),
    .rdata (vis_q)
  );

  gdfs_ram #(.WIDTH(EW), .DEPTH(CELLS)) u_stack (
    .clk   (clk),
    .we    (cmd.push),
    .waddr (depth[SAW-1:0]),
    .wdata ({cur_row, cur_col, dir}),
    .raddr (cmd.active ? depth_m1[SAW-1:0] : idx_x[SAW-1:0]),
    .rdata (stk_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      depth    <= '0;
      found    <= 1'b0;
      done     <= 1'b0;
      rd_valid <= 1'b0;
    end else begin
      done     <= cmd.finish || (accept && (req.cmd != gdfs_pkg::CMD_SOLVE));
      rd_valid <= accept && (req.cmd == gdfs_pkg::CMD_READ) && idx_hit;
      if (cmd.init) begin
        depth <= '0;
        found <= 1'b0;
      end
      if (cmd.push) begin
        depth <= depth + DW'(1);
      end
      if (cmd.pop_rd) begin
        depth <= depth_m1;
      end
      if (cmd.set_found) begin
        found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      cur_row <= start_row_x[RW-1:0];
      cur_col <= start_col_x[CW-1:0];
      clr_cnt <= '0;
    end
    if (cmd.clr_we) begin
      clr_cnt <= clr_cnt + MW'(1);
    end
    if (cmd.visit) begin
      dir <= gdfs_pkg::DIR_DOWN;
    end
    if (cmd.next_dir) begin
      dir <= dir + 2'd1;
    end
    if (cmd.push) begin
      cur_row <= nb_row;
      cur_col <= nb_col;
    end
    if (cmd.pop_load) begin
      cur_row <= stk_q[EW-1 -: RW];
      cur_col <= stk_q[CW+1 -: CW];
    end
  end

  assign len_x      = LW'(depth);
  assign step_row_x = ORW'(stk_q[EW-1 -: RW]);
  assign step_col_x = OCW'(stk_q[CW+1 -: CW]);

  assign res.found       = found;
  assign res.path_length = len_x[gdfs_pkg::LEN_W-1:0];
  assign res.step_row    = rd_valid ? step_row_x[gdfs_pkg::ROW_W-1:0] : '0;
  assign res.step_col    = rd_valid ? step_col_x[gdfs_pkg::COL_W-1:0] : '0;
  assign res.step_dir    = rd_valid ? stk_q[1:0] : 2'd0;
  assign res.index_valid = rd_valid;

endmodule

FILE: rtl/core/grid_maze_dfs_solver.sv
// ----------------------------------------------------------------------------
// grid_maze_dfs_solver
// Depth-first grid maze solver with cell load, solve and path readback.
// ----------------------------------------------------------------------------
// A cell write or a path read is taken back to back, and its result is
// strobed on done in the following cycle. A solve holds busy for the whole
// walk. First it clears all 2^(clog2(MAX_ROWS)+clog2(MAX_COLS)) entries of
// the visited map (4096 with the default 64x64). After that it marks each
// cell the walk stands on: the start, each cell moved into other than the
// exit, and each cell backed into. A direction off the grid or blocked by a
// full stack is passed over in the probe state; one that needs a map lookup
// goes through the probe and check states. Each backtrack goes through the
// stuck and pop states, and a walk that never reaches the exit ends in the
// stuck state at the start. Every neighbor lookup uses the single-read,
// registered-read map RAMs. The result of the solve is strobed on done in
// the cycle busy drops. Results are never held back: the receiver must take
// done when it is shown. The user must write the grid size and exit registers
// over the APB port only while the block is idle; nothing enforces it.
module grid_maze_dfs_solver #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  gdfs_pkg::req_t  req,
  output logic            done,
  output gdfs_pkg::res_t  res,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [3:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);

  localparam int MAXR7 = (MAX_ROWS > 127) ? 127 : MAX_ROWS;
  localparam int MAXC7 = (MAX_COLS > 127) ? 127 : MAX_COLS;
  localparam int RST_ROWS = (MAX_ROWS < 64) ? MAX_ROWS : 64;
  localparam int RST_COLS = (MAX_COLS < 64) ? MAX_COLS : 64;

  logic [gdfs_pkg::DIM_W-1:0] grid_rows;
  logic [gdfs_pkg::DIM_W-1:0] grid_cols;
  logic [gdfs_pkg::ROW_W-1:0] exit_row;
  logic [gdfs_pkg::COL_W-1:0] exit_col;
  logic [gdfs_pkg::DIM_W-1:0] wr_dim;
  logic [gdfs_pkg::DIM_W-1:0] sat_rows;
  logic [gdfs_pkg::DIM_W-1:0] sat_cols;
  logic                       cfg_we;
  logic                       accept;

  gdfs_pkg::ctrl_cmd_t ctrl_cmd;
  gdfs_pkg::ctrl_sts_t ctrl_sts;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;
  assign wr_dim = pwdata[gdfs_pkg::DIM_W-1:0];

  assign sat_rows = (wr_dim < gdfs_pkg::DIM_MIN) ? gdfs_pkg::DIM_MIN :
                    (wr_dim > gdfs_pkg::DIM_W'(MAXR7)) ? gdfs_pkg::DIM_W'(MAXR7) : wr_dim;
  assign sat_cols = (wr_dim < gdfs_pkg::DIM_MIN) ? gdfs_pkg::DIM_MIN :
                    (wr_dim > gdfs_pkg::DIM_W'(MAXC7)) ? gdfs_pkg::DIM_W'(MAXC7) : wr_dim;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_rows <= gdfs_pkg::DIM_W'(RST_ROWS);
      grid_cols <= gdfs_pkg::DIM_W'(RST_COLS);
      exit_row  <= '0;
      exit_col  <= gdfs_pkg::COL_W'(1);
    end else if (cfg_we) begin
      case (paddr[3:2])
        gdfs_pkg::REG_GRID_ROWS: grid_rows <= sat_rows;
        gdfs_pkg::REG_GRID_COLS: grid_cols <= sat_cols;
        gdfs_pkg::REG_EXIT_ROW:  exit_row  <= pwdata[gdfs_pkg::ROW_W-1:0];
        gdfs_pkg::REG_EXIT_COL:  exit_col  <= pwdata[gdfs_pkg::COL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      gdfs_pkg::REG_GRID_ROWS: prdata = 32'(grid_rows);
      gdfs_pkg::REG_GRID_COLS: prdata = 32'(grid_cols);
      gdfs_pkg::REG_EXIT_ROW:  prdata = 32'(exit_row);
      gdfs_pkg::REG_EXIT_COL:  prdata = 32'(exit_col);
      default:                 prdata = '0;
    endcase
  end

  assign busy   = ctrl_cmd.active;
  assign accept = start && !busy;

  gdfs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .solve_go (accept && (req.cmd == gdfs_pkg::CMD_SOLVE)),
    .sts      (ctrl_sts),
    .cmd      (ctrl_cmd)
  );

  gdfs_dp #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .req       (req),
    .grid_rows (grid_rows),
    .grid_cols (grid_cols),
    .exit_row  (exit_row),
    .exit_col  (exit_col),
    .cmd       (ctrl_cmd),
    .sts       (ctrl_sts),
    .done      (done),
    .res       (res)
  );

  // a result never overlaps a running walk
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobed while walk running");

  a_quick_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (req.cmd != gdfs_pkg::CMD_SOLVE)) |=> done)
    else $error("write or read request gave no result next cycle");

  a_solve_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (req.cmd == gdfs_pkg::CMD_SOLVE)) |=> (busy && !done))
    else $error("solve request did not start the walk");

  a_valid_from_read: assert property (@(posedge clk) disable iff (rst)
    (done && res.index_valid) |->
      $past(start && !busy && (req.cmd == gdfs_pkg::CMD_READ)))
    else $error("index_valid without a path read");

endmodule
